[rtl/core/pars_pkg.sv]
// pars_pkg: shared widths, operation codes and sequencer state type
// for the point update / range sum block. No dependencies.
`default_nettype none

package pars_pkg;

  // Fixed transaction field widths
  localparam int MODE_W = 2;
  localparam int POS_W  = 13;
  localparam int AMT_W  = 32;
  localparam int SUM_W  = 64;

  // Operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  // unused code: taken and ignored, no response
  localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_UPD_RD = 6'b000100,
    S_UPD_WR = 6'b001000,
    S_QRY    = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

endpackage

`default_nettype wire

[rtl/core/pars_if.sv]
// pars_if: valid/ready channel interfaces for requests and responses.
// Depends on pars_pkg for field widths.
`default_nettype none

interface pars_req_if;
  logic                              valid;
  logic                              ready;
  logic [pars_pkg::MODE_W-1:0]       mode;
  logic [pars_pkg::POS_W-1:0]        position;
  logic signed [pars_pkg::AMT_W-1:0] amount;
  logic [pars_pkg::POS_W-1:0]        right_bound;

  modport source (output valid, mode, position, amount, right_bound, input ready);
  modport sink   (input valid, mode, position, amount, right_bound, output ready);
endinterface

interface pars_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [pars_pkg::SUM_W-1:0] range_sum;

  modport source (output valid, range_sum, input ready);
  modport sink   (input valid, range_sum, output ready);
endinterface

`default_nettype wire

[rtl/core/pars_ram.sv]
// pars_ram: single-port tree node memory, registered read data.
// Depends on pars_pkg for the data width.
`default_nettype none

module pars_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               addr,
  input  wire logic [pars_pkg::SUM_W-1:0]  wdata,
  output logic      [pars_pkg::SUM_W-1:0]  rdata
);

  logic [pars_pkg::SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[rtl/core/point_add_range_sum.sv]
// point_add_range_sum: top level, point update / range sum query engine.
// Depends on pars_pkg, pars_if (pars_req_if, pars_rsp_if) and pars_ram.
`default_nettype none

// The block keeps POSITIONS signed 64-bit cells (positions 1..POSITIONS) as a
// binary indexed (Fenwick) tree in one single-port memory, driven by a small
// sequencer and one shared 64-bit add/subtract unit. After reset a clearing
// pass writes zero to every tree node, one node per cycle, so req.ready stays
// low until the pass ends. An add or subtract walks upward through the tree,
// reading then writing back each node; positions outside 1..POSITIONS and
// the unused mode code are dropped. A query walks down from the clamped right
// bound, then from the left bound minus one, reading one node per cycle into
// the accumulator, and the finish step then loads the sum into the response
// register. One transaction is in flight at a time; a finished sum sits in
// the response register, so the next request can be taken while the response
// waits. A query that finishes while an earlier response is still waiting
// holds in its finish step until that response is taken. Sums wrap at 64
// bits.
module point_add_range_sum #(
  parameter int POSITIONS = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pars_req_if.sink    req,
  pars_rsp_if.source  rsp
);

  // Tree index width: KW holds up to 2*POSITIONS (upward walk overshoot).
  localparam int IW = $clog2(POSITIONS + 1);
  localparam int KW = IW + 1;
  localparam int AW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  // Compare width covering both the 13-bit fields and POSITIONS
  localparam int XW = ((KW > pars_pkg::POS_W) ? KW : pars_pkg::POS_W) + 1;

  localparam logic [KW-1:0] N_K = KW'(POSITIONS);
  localparam logic [XW-1:0] N_X = XW'(POSITIONS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(POSITIONS - 1);

  pars_pkg::state_t state;

  logic [KW-1:0]                  k;        // current tree index
  logic [KW-1:0]                  lo_k;     // second query bound
  logic                           pend;     // query read in flight
  logic                           second;   // working on left bound
  logic                           sub_op;   // update is a subtract
  logic [pars_pkg::AMT_W-1:0]     amt;
  logic [pars_pkg::SUM_W-1:0]     acc;
  logic [AW-1:0]                  clr;
  logic                           rsp_valid;
  logic [pars_pkg::SUM_W-1:0]     rsp_sum;

  // Memory port
  logic                           ram_we;
  logic [AW-1:0]                  ram_addr;
  logic [pars_pkg::SUM_W-1:0]     ram_wdata;
  logic [pars_pkg::SUM_W-1:0]     ram_rdata;

  // Shared add/subtract unit
  logic                           upd;
  logic [pars_pkg::SUM_W-1:0]     op_a;
  logic [pars_pkg::SUM_W-1:0]     op_b;
  logic                           op_sub;
  logic [pars_pkg::SUM_W-1:0]     op_sum;

  // Index helpers
  logic [KW-1:0]                  lowbit;
  logic [XW-1:0]                  pos_x;
  logic [XW-1:0]                  right_x;
  logic [KW-1:0]                  hi_idx;
  logic [KW-1:0]                  lo_idx;
  logic                           pos_ok;
  logic                           req_fire;

  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state == pars_pkg::S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.range_sum = rsp_sum;

  // lowest set bit of the tree index
  assign lowbit = k & (~k + KW'(1));

  // Bound decode: clamp at POSITIONS; left bound of zero gives an empty prefix
  always_comb begin
    pos_x   = XW'(req.position);
    right_x = XW'(req.right_bound);
    pos_ok  = (pos_x != '0) && (pos_x <= N_X);
    if (right_x > N_X) begin
      hi_idx = N_K;
    end else begin
      hi_idx = KW'(right_x);
    end
    if (pos_x == '0) begin
      lo_idx = '0;
    end else if ((pos_x - XW'(1)) > N_X) begin
      lo_idx = N_K;
    end else begin
      lo_idx = KW'(pos_x - XW'(1));
    end
  end

  // Update: node +/- amount. Query: acc +/- node.
  assign upd    = (state == pars_pkg::S_UPD_WR);
  assign op_a   = upd ? ram_rdata : acc;
  assign op_b   = upd ? {{(pars_pkg::SUM_W - pars_pkg::AMT_W){amt[pars_pkg::AMT_W-1]}}, amt}
                      : ram_rdata;
  assign op_sub = upd ? sub_op : second;
  assign op_sum = op_sub ? (op_a - op_b) : (op_a + op_b);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(k - KW'(1));
    ram_wdata = op_sum;
    if (state == pars_pkg::S_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr;
      ram_wdata = '0;
    end else if (state == pars_pkg::S_UPD_WR) begin
      ram_we = 1'b1;
    end
  end

  pars_ram #(
    .DEPTH (POSITIONS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pars_pkg::S_CLEAR;
      clr       <= '0;
      pend      <= 1'b0;
      second    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // the finish step owns rsp_valid in its own cycle
      if (rsp_valid && rsp.ready && (state != pars_pkg::S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        pars_pkg::S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == LAST_ADDR) begin
            state <= pars_pkg::S_IDLE;
          end
        end
        pars_pkg::S_IDLE: begin
          if (req_fire) begin
            amt    <= req.amount;
            sub_op <= (req.mode == pars_pkg::MODE_SUB);
            priority if ((req.mode == pars_pkg::MODE_ADD ||
                          req.mode == pars_pkg::MODE_SUB) && pos_ok) begin
              k     <= KW'(pos_x);
              state <= pars_pkg::S_UPD_RD;
            end else if (req.mode == pars_pkg::MODE_QUERY) begin
              k      <= hi_idx;
              lo_k   <= lo_idx;
              acc    <= '0;
              pend   <= 1'b0;
              second <= 1'b0;
              state  <= pars_pkg::S_QRY;
            end else begin
              state <= pars_pkg::S_IDLE;
            end
          end
        end
        pars_pkg::S_UPD_RD: begin
          // read issued this cycle unless the walk has left the tree
          if (k > N_K) begin
            state <= pars_pkg::S_IDLE;
          end else begin
            state <= pars_pkg::S_UPD_WR;
          end
        end
        pars_pkg::S_UPD_WR: begin
          k     <= k + lowbit;
          state <= pars_pkg::S_UPD_RD;
        end
        pars_pkg::S_QRY: begin
          if (pend) begin
            acc <= op_sum;
          end
          if (k != '0) begin
            k    <= k - lowbit;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (!second) begin
                second <= 1'b1;
                k      <= lo_k;
              end else begin
                state <= pars_pkg::S_FIN;
              end
            end
          end
        end
        pars_pkg::S_FIN: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_sum   <= acc;
            state     <= pars_pkg::S_IDLE;
          end
        end
        default: begin
          state <= pars_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // write-back always targets a real tree node
  a_upd_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == pars_pkg::S_UPD_WR) |-> (k != '0 && k <= N_K))
    else $error("update walk wrote outside the tree");

  // query walk never starts above the clamped bound
  a_qry_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == pars_pkg::S_QRY) |-> (k <= N_K))
    else $error("query index beyond tree size");

  // a new response only comes out of the finish step
  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == pars_pkg::S_FIN))
    else $error("response raised outside finish");

  // the sum is published only once both walks drained
  a_fin_drained: assert property (@(posedge clk) disable iff (rst)
    (state == pars_pkg::S_FIN) |-> (!pend && second && k == '0))
    else $error("query finished with reads outstanding");
`endif

endmodule

`default_nettype wire
